// ----- sv/ercf_pkg.sv -----
// ercf_pkg: shared types, constants and crc matrix builders for the event
// record fingerprint block
// no dependencies
`timescale 1ns / 1ps

package ercf_pkg;

  // record layout
  localparam int RecordBytes = 64;
  localparam int RecordBits  = RecordBytes * 8;
  localparam int CrcWidth    = 32;
  localparam int MaskWidth   = 64;
  localparam int CountWidth  = 64;

  // reflected crc-32c, no final xor
  localparam logic [CrcWidth-1:0] CrcPoly = 32'h82F6_3B78;
  localparam logic [CrcWidth-1:0] CrcInit = 32'hFFFF_FFFF;

  localparam logic [MaskWidth-1:0] MaskReset = 64'd63;

  typedef enum logic [1:0] {
    ST_ACCEPTED     = 2'd0,
    ST_BAD_TYPE     = 2'd1,
    ST_NONCANONICAL = 2'd2
  } status_t;

  // one row per crc output bit, one column per input bit
  typedef logic [CrcWidth-1:0][RecordBits-1:0] data_rows_t;
  typedef logic [CrcWidth-1:0][CrcWidth-1:0]   init_rows_t;

  // one lsb-first shift of the crc register with a zero input bit
  function automatic logic [CrcWidth-1:0] crc_zero_step(logic [CrcWidth-1:0] c);
    return {1'b0, c[CrcWidth-1:1]} ^ (c[0] ? CrcPoly : '0);
  endfunction

  // contribution of each record bit to the crc, starting from a zero register
  function automatic data_rows_t build_data_rows();
    data_rows_t rows;
    logic [CrcWidth-1:0] col;
    rows = '0;
    col  = CrcPoly;
    for (int i = RecordBits - 1; i >= 0; i--) begin
      for (int j = 0; j < CrcWidth; j++) begin
        rows[j][i] = col[j];
      end
      col = crc_zero_step(col);
    end
    return rows;
  endfunction

  // contribution of each old crc bit after a full record of shifts
  function automatic init_rows_t build_init_rows();
    init_rows_t rows;
    logic [CrcWidth-1:0] c;
    rows = '0;
    for (int k = 0; k < CrcWidth; k++) begin
      c = '0;
      c[k] = 1'b1;
      for (int s = 0; s < RecordBits; s++) begin
        c = crc_zero_step(c);
      end
      for (int j = 0; j < CrcWidth; j++) begin
        rows[j][k] = c[j];
      end
    end
    return rows;
  endfunction

endpackage

// ----- sv/event_record_crc32c_fingerprint.sv -----
// event_record_crc32c_fingerprint: checks event records and folds each
// accepted one into a running crc-32c, with event and byte counters
// depends on ercf_pkg
`timescale 1ns / 1ps

// One event record beat enters per clock while the result side keeps up,
// and each gives one result beat; the block only stalls on back-pressure
// from out_tready. The record is latched in an input register, then the type
// mask and reserved checks and the whole 64-byte crc-32c fold (reflected,
// polynomial 0x82F63B78, start value 0xFFFFFFFF, no final xor) are done as
// one parallel xor matrix into the result register; the 32-bit crc register
// and the two counters are the state carried from one record to the next.
// A rejected record (status 1 bad type, status 2 nonzero reserved field,
// type checked first) leaves crc and counters unchanged and reports their
// current values. allowed_type_mask is written over the cfg port, which is
// always ready, and should only be written while no record is in flight.
module event_record_crc32c_fingerprint (
  input  logic         clk,
  input  logic         rst_n,

  // record input
  input  logic         in_tvalid,
  output logic         in_tready,
  // cmd_seq_num[63:0], order_ident[127:64], other_order_ident[191:128],
  // price_ticks[255:192], qty[319:256], other_qty[383:320],
  // slot_index[415:384], slot_generation[447:416], event_number[479:448],
  // reason_code[487:480], reserved_bits[503:488]
  input  logic [503:0] in_tdata,
  // type_code[7:0]
  input  logic [7:0]   in_tuser,

  // result output
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], fingerprint[33:2], events_seen[97:34], bytes_seen[161:98],
  // zero[167:162]
  output logic [167:0] out_tdata,

  // allowed_type_mask write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [63:0]  cfg_data
);

  localparam int RecBits  = ercf_pkg::RecordBits;
  localparam int CrcW     = ercf_pkg::CrcWidth;
  localparam int CntW     = ercf_pkg::CountWidth;
  // bytes 0-61 carry data, bytes 62-63 are always zero
  localparam int LiveBits = RecBits - 16;

  localparam ercf_pkg::data_rows_t DataRows = ercf_pkg::build_data_rows();
  localparam ercf_pkg::init_rows_t InitRows = ercf_pkg::build_init_rows();

  localparam logic [CntW-1:0] BytesPerRec = CntW'(ercf_pkg::RecordBytes);

  // configuration register
  logic [ercf_pkg::MaskWidth-1:0] mask_r;

  // input stage
  logic                in_vld_r;
  logic [LiveBits-1:0] rec_r;
  logic                resv_nz_r;

  // running state
  logic [CrcW-1:0] crc_r;
  logic [CntW-1:0] events_r;
  logic [CntW-1:0] bytes_r;

  // result stage
  logic                 out_vld_r;
  ercf_pkg::status_t    out_status_r;
  logic [CrcW-1:0]      out_fp_r;
  logic [CntW-1:0]      out_events_r;
  logic [CntW-1:0]      out_bytes_r;

  logic                 adv;
  logic [LiveBits-1:0]  rec_nxt;
  logic [RecBits-1:0]   rec_full;
  logic [7:0]           type_code;
  logic                 type_ok;
  ercf_pkg::status_t    status_nxt;
  logic [CrcW-1:0]      crc_calc;
  logic [CrcW-1:0]      crc_nxt;
  logic [CntW-1:0]      events_nxt;
  logic [CntW-1:0]      bytes_nxt;

  // handshakes
  assign cfg_ready = 1'b1;
  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  // little-endian record image: tdata fields then type and reason bytes
  assign rec_nxt = {in_tdata[487:480], in_tuser, in_tdata[479:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= ercf_pkg::MaskReset;
    end else if (cfg_valid && cfg_ready) begin
      mask_r <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      rec_r     <= rec_nxt;
      resv_nz_r <= |in_tdata[503:488];
    end
  end

  // record checks, type first
  assign type_code = rec_r[487:480];
  assign type_ok   = (type_code[7:6] == 2'b00) && mask_r[type_code[5:0]];

  always_comb begin
    priority if (!type_ok) begin
      status_nxt = ercf_pkg::ST_BAD_TYPE;
    end else if (resv_nz_r) begin
      status_nxt = ercf_pkg::ST_NONCANONICAL;
    end else begin
      status_nxt = ercf_pkg::ST_ACCEPTED;
    end
  end

  // parallel crc fold of the whole record
  assign rec_full = {16'h0000, rec_r};

  always_comb begin
    for (int j = 0; j < CrcW; j++) begin
      crc_calc[j] = (^(rec_full & DataRows[j])) ^ (^(crc_r & InitRows[j]));
    end
  end

  // state update only for accepted records
  always_comb begin
    if (status_nxt == ercf_pkg::ST_ACCEPTED) begin
      crc_nxt    = crc_calc;
      events_nxt = events_r + CntW'(1);
      bytes_nxt  = bytes_r + BytesPerRec;
    end else begin
      crc_nxt    = crc_r;
      events_nxt = events_r;
      bytes_nxt  = bytes_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= ercf_pkg::CrcInit;
      events_r <= '0;
      bytes_r  <= '0;
    end else if (adv) begin
      crc_r    <= crc_nxt;
      events_r <= events_nxt;
      bytes_r  <= bytes_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= status_nxt;
      out_fp_r     <= crc_nxt;
      out_events_r <= events_nxt;
      out_bytes_r  <= bytes_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, out_bytes_r, out_events_r, out_fp_r, out_status_r};

  // byte count always tracks the event count
  a_bytes_track: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_r == {events_r[CntW-7:0], 6'b0})
    else $error("byte counter out of step with event counter");

  // a rejected record leaves the crc untouched
  a_reject_holds_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && status_nxt != ercf_pkg::ST_ACCEPTED) |=> $stable(crc_r))
    else $error("crc changed on a rejected record");

  // an accepted record advances the event count by one
  a_accept_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && status_nxt == ercf_pkg::ST_ACCEPTED) |=>
      events_r == $past(events_r) + CntW'(1))
    else $error("event counter did not advance");

  // a result that leaves the block reports the running state it was built with
  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_fp_r == crc_r && out_events_r == events_r))
    else $error("result beat does not match running state");

endmodule

// ----- tb/tb_event_record_crc32c_fingerprint.sv -----
// tb_event_record_crc32c_fingerprint: self-checking bench for the event record
// fingerprint block, with a scoreboard that tracks crc, counters and mask
// depends on ercf_pkg and event_record_crc32c_fingerprint
`timescale 1ns / 1ps

// one event record as the bench builds it; type_code travels on tuser
typedef struct packed {
  logic [15:0]        reserved_bits;
  logic [7:0]         reason_code;
  logic [31:0]        event_number;
  logic [31:0]        slot_generation;
  logic [31:0]        slot_index;
  logic [63:0]        other_qty;
  logic [63:0]        qty;
  logic signed [63:0] price_ticks;
  logic [63:0]        other_order_ident;
  logic [63:0]        order_ident;
  logic [63:0]        cmd_seq_num;
  logic [7:0]         type_code;
} event_rec_t;

typedef struct packed {
  ercf_pkg::status_t status;
  logic [31:0]       fingerprint;
  logic [63:0]       events_seen;
  logic [63:0]       bytes_seen;
} fp_result_t;

// running fingerprint state and the results it still owes
class fingerprint_scoreboard;
  logic [ercf_pkg::MaskWidth-1:0]  type_mask;
  logic [ercf_pkg::CrcWidth-1:0]   crc_state;
  logic [ercf_pkg::CountWidth-1:0] accepted_events;
  logic [ercf_pkg::CountWidth-1:0] byte_count;
  fp_result_t                      expected_q[$];
  int unsigned                     mismatches;

  function new();
    type_mask       = ercf_pkg::MaskReset;
    crc_state       = ercf_pkg::CrcInit;
    accepted_events = '0;
    byte_count      = '0;
    mismatches      = 0;
  endfunction

  function void set_mask(logic [ercf_pkg::MaskWidth-1:0] m);
    type_mask = m;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  // bit-serial reflected crc over the 64-byte record, byte 0 in the low bits
  function logic [ercf_pkg::CrcWidth-1:0] fold_record(
      logic [ercf_pkg::CrcWidth-1:0] crc, logic [ercf_pkg::RecordBits-1:0] rec);
    logic [ercf_pkg::CrcWidth-1:0] c;
    logic                          feedback;
    c = crc;
    for (int i = 0; i < ercf_pkg::RecordBits; i++) begin
      feedback = c[0] ^ rec[i];
      c = c >> 1;
      if (feedback) c = c ^ ercf_pkg::CrcPoly;
    end
    return c;
  endfunction

  // accepted input beat: type check first, then reserved field, then hash
  function void note_record(logic [503:0] data, logic [7:0] type_code);
    fp_result_t res;
    logic [15:0] reserved;
    reserved = data[503:488];
    if (type_code >= 8'd64 || !type_mask[type_code[5:0]]) begin
      res.status = ercf_pkg::ST_BAD_TYPE;
    end else if (reserved != '0) begin
      res.status = ercf_pkg::ST_NONCANONICAL;
    end else begin
      res.status      = ercf_pkg::ST_ACCEPTED;
      crc_state       = fold_record(crc_state,
                                    {16'h0000, data[487:480], type_code, data[479:0]});
      accepted_events = accepted_events + 64'd1;
      byte_count      = byte_count + 64'(ercf_pkg::RecordBytes);
    end
    res.fingerprint = crc_state;
    res.events_seen = accepted_events;
    res.bytes_seen  = byte_count;
    expected_q.push_back(res);
  endfunction

  // accepted result beat against the oldest outstanding expectation
  function void check_result(logic [167:0] beat);
    fp_result_t want;
    if (expected_q.size() == 0) begin
      $error("result beat with no record outstanding");
      mismatches++;
      return;
    end
    want = expected_q.pop_front();
    if (beat[1:0] !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, beat[1:0]);
      mismatches++;
    end
    if (beat[33:2] !== want.fingerprint) begin
      $error("fingerprint: expected %0h, got %0h", want.fingerprint, beat[33:2]);
      mismatches++;
    end
    if (beat[97:34] !== want.events_seen) begin
      $error("events_seen: expected %0h, got %0h", want.events_seen, beat[97:34]);
      mismatches++;
    end
    if (beat[161:98] !== want.bytes_seen) begin
      $error("bytes_seen: expected %0h, got %0h", want.bytes_seen, beat[161:98]);
      mismatches++;
    end
  endfunction
endclass

module tb_event_record_crc32c_fingerprint;

  localparam int SettleCycles  = 4;
  localparam int HoldOffCycles = 300;
  localparam int WatchdogLimit = 2000;
  localparam int PhaseRecords  = 255;
  localparam int NumPhases     = 6;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  // cmd_seq_num, order_ident, other_order_ident, price_ticks, qty,
  // other_qty, slot_index, slot_generation, event_number, reason_code,
  // reserved_bits
  logic [503:0] in_tdata   = '0;
  // type_code
  logic [7:0]   in_tuser   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // status, fingerprint, events_seen, bytes_seen, zero pad
  logic [167:0] out_tdata;
  logic         cfg_valid  = 1'b0;
  logic         cfg_ready;
  logic [63:0]  cfg_data   = '0;

  fingerprint_scoreboard sb;
  bit burst_mode    = 1'b0;
  bit hold_request  = 1'b0;
  int quiet_cycles  = 0;

  event_record_crc32c_fingerprint dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // mostly no gap, some short ones, a few long
  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // zero, all ones, small or fully random
  function automatic logic [63:0] wide_value();
    unique case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // mostly allowed types with a clean reserved field, the rest random types or dirty reserved fields
  function automatic event_rec_t random_record(logic [63:0] mask);
    event_rec_t r;
    int pick;
    r.cmd_seq_num       = wide_value();
    r.order_ident       = wide_value();
    r.other_order_ident = wide_value();
    r.price_ticks       = wide_value();
    r.qty               = wide_value();
    r.other_qty         = wide_value();
    r.slot_index        = 32'(wide_value());
    r.slot_generation   = 32'(wide_value());
    r.event_number      = 32'(wide_value());
    r.reason_code       = 8'(wide_value());
    pick = $urandom_range(0, 99);
    if (pick < 70 && mask != '0) begin
      do r.type_code = 8'($urandom_range(0, 63)); while (!mask[r.type_code[5:0]]);
    end else if (pick < 85) begin
      r.type_code = 8'($urandom_range(0, 255));
    end else begin
      r.type_code = 8'($urandom_range(0, 63));
    end
    pick = $urandom_range(0, 99);
    if (pick < 85) r.reserved_bits = '0;
    else if (pick < 93) r.reserved_bits = 16'd1 << $urandom_range(0, 15);
    else r.reserved_bits = 16'($urandom_range(1, 65535));
    return r;
  endfunction

  // offer one record beat and wait for its handshake
  task automatic send_record(input event_rec_t r);
    int gap;
    gap = burst_mode ? 0 : idle_length();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r.reserved_bits, r.reason_code, r.event_number, r.slot_generation,
                  r.slot_index, r.other_qty, r.qty, r.price_ticks, r.other_order_ident,
                  r.order_ident, r.cmd_seq_num};
    in_tuser  <= r.type_code;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering, wait for every owed result, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_mask(input logic [63:0] m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_mask(m);
  endtask

  // result side: random stalls, ready stretches, one long hold-off on request
  initial begin
    int n;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end else begin
        n = idle_length();
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        if (!hold_request) begin
          out_tready <= 1'b1;
          n = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                            : $urandom_range(1, 24);
          // a hold-off request cuts the ready stretch short
          for (int k = 0; k < n && !hold_request; k++) @(posedge clk);
        end
      end
    end
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_record(in_tdata, in_tuser);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : stimulus
    event_rec_t rec;
    logic [63:0] phase_mask;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed records under the reset mask
    rec = '0;
    send_record(rec);
    rec = '1;
    rec.type_code = 8'd5;
    rec.reserved_bits = '0;
    send_record(rec);
    rec = '0;
    rec.price_ticks = 64'h8000_0000_0000_0000;
    rec.type_code = 8'd1;
    send_record(rec);
    rec.price_ticks = 64'h7FFF_FFFF_FFFF_FFFF;
    rec.type_code = 8'd2;
    send_record(rec);
    // types outside the mask, including codes with no mask bit at all
    rec.type_code = 8'd6;
    send_record(rec);
    rec.type_code = 8'd63;
    send_record(rec);
    rec.type_code = 8'd64;
    send_record(rec);
    // bad type and dirty reserved field together
    rec.type_code = 8'd255;
    rec.reserved_bits = 16'hFFFF;
    send_record(rec);
    // noncanonical reserved field with an allowed type
    rec.type_code = 8'd0;
    rec.reserved_bits = 16'h0001;
    send_record(rec);
    rec.type_code = 8'd3;
    rec.reserved_bits = 16'h8000;
    send_record(rec);
    repeat (3) send_record(random_record(ercf_pkg::MaskReset));

    // every mask bit set, codes 64 and up still rejected
    write_mask('1);
    rec = random_record('1);
    rec.reserved_bits = '0;
    rec.type_code = 8'd63;
    send_record(rec);
    rec.type_code = 8'd64;
    send_record(rec);
    rec.type_code = 8'd255;
    send_record(rec);

    // nothing allowed
    write_mask('0);
    rec.type_code = 8'd0;
    send_record(rec);
    rec = '1;
    send_record(rec);

    // only the top type allowed
    write_mask(64'h8000_0000_0000_0000);
    rec = '0;
    rec.type_code = 8'd63;
    send_record(rec);
    rec.type_code = 8'd62;
    send_record(rec);
    rec.type_code = 8'd63;
    rec.reserved_bits = 16'h0100;
    send_record(rec);

    // random phases, each under its own mask
    for (int p = 0; p < NumPhases; p++) begin
      unique case (p)
        0: phase_mask = ercf_pkg::MaskReset;
        2: phase_mask = '1;
        4: phase_mask = 64'h8000_0000_0000_0001;
        default: phase_mask = {$urandom, $urandom};
      endcase
      write_mask(phase_mask);
      // back-to-back records against a long result stall fill the block
      burst_mode = (p == 1);
      if (p == 1) hold_request = 1'b1;
      for (int i = 0; i < PhaseRecords; i++) begin
        if (p == 3 && i == PhaseRecords / 2) drain();
        send_record(random_record(phase_mask));
      end
      burst_mode = 1'b0;
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- event_record_crc32c_fingerprint.f -----
sv/ercf_pkg.sv
sv/event_record_crc32c_fingerprint.sv
tb/tb_event_record_crc32c_fingerprint.sv
